[src/spd_pkg.sv]
// shared types, constants and level helpers for the stereo peak meter
// no dependencies; imported by every module of the block
package spd_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int PEAK_W       = 16;
  localparam int BAR_SEGMENTS = 67;
  localparam int BAR_W        = 7;
  localparam int CFG_W        = 16;
  localparam int CFG_ADDR_W   = 2;
  localparam int LOG_IN_W     = 16;
  localparam int LOG_E_W      = 4;
  localparam int LOG_FRAC_W   = 16;
  localparam int MANT_W       = 31;
  localparam int DB_W         = 15;
  localparam int LVL_W        = 10;
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = 1;
  localparam int FIFO_CNT_W   = 2;

  // 20*log10(2) in Q16
  localparam logic [18:0] DB_PER_OCTAVE_Q16 = 19'd394566;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_REF_AMPLITUDE       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_AMPLITUDE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAMES_PER_BLOCK    = 2'd2;

  localparam logic [CFG_W-1:0] REF_RESET = 16'd32768;
  localparam logic [CFG_W-1:0] THR_RESET = 16'd8231;
  localparam logic [CFG_W-1:0] FPB_RESET = 16'd4096;

  typedef struct packed {
    logic [PEAK_W-1:0] right_peak;
    logic [PEAK_W-1:0] left_peak;
  } peak_pair_t;

  typedef struct packed {
    logic       valid;
    peak_pair_t pair;
  } front_push_t;

  typedef struct packed {
    logic       not_empty;
    peak_pair_t pair;
  } fifo_rd_t;

  typedef struct packed {
    logic [BAR_W-1:0]  right_red_count;
    logic [BAR_W-1:0]  left_red_count;
    logic [BAR_W-1:0]  right_bar;
    logic [BAR_W-1:0]  left_bar;
    logic [PEAK_W-1:0] right_peak;
    logic [PEAK_W-1:0] left_peak;
  } result_t;

  typedef enum logic [1:0] {
    LOG_IDLE,
    LOG_ITER,
    LOG_SCALE
  } log_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_START,
    BK_WAIT,
    BK_LEVEL,
    BK_OUT
  } back_state_t;

  // truncated level index: (BAR_SEGMENTS*256 + db - db_ref)/256, toward zero
  function automatic logic signed [LVL_W-1:0] level_of(input logic [DB_W-1:0] db,
                                                       input logic [DB_W-1:0] db_ref);
    logic signed [17:0] v;
    logic signed [17:0] nv;
    v  = 18'(BAR_SEGMENTS * 256) + 18'(db) - 18'(db_ref);
    nv = -v;
    if (v >= 0) begin
      level_of = LVL_W'(v >>> 8);
    end else begin
      level_of = -LVL_W'(nv >>> 8);
    end
  endfunction

  function automatic logic [BAR_W-1:0] bar_of(input logic signed [LVL_W-1:0] idx);
    if (idx < 0) begin
      bar_of = '0;
    end else if (idx > LVL_W'(BAR_SEGMENTS)) begin
      bar_of = BAR_W'(BAR_SEGMENTS);
    end else begin
      bar_of = idx[BAR_W-1:0];
    end
  endfunction

  function automatic logic [BAR_W-1:0] red_of(input logic [BAR_W-1:0] bar,
                                              input logic signed [LVL_W-1:0] ti);
    if (ti < 0 || ti >= $signed({{(LVL_W-BAR_W){1'b0}}, bar})) begin
      red_of = '0;
    end else begin
      red_of = bar - ti[BAR_W-1:0];
    end
  endfunction

endpackage

[src/spd_front.sv]
// front end: takes stereo frames, tracks per-channel peaks and block count
// depends on spd_pkg; pushes finished peak pairs toward spd_fifo
module spd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [spd_pkg::SAMPLE_BITS-1:0] left_sample,
  input  logic [spd_pkg::SAMPLE_BITS-1:0] right_sample,
  input  logic [spd_pkg::CFG_W-1:0]     frames_per_block,
  input  logic                          fifo_full,
  output spd_pkg::front_push_t          push
);
  import spd_pkg::*;

  logic [CFG_W-1:0]  cnt_r, cnt_nxt;
  logic [PEAK_W-1:0] lhold_r, lhold_nxt;
  logic [PEAK_W-1:0] rhold_r, rhold_nxt;
  logic [PEAK_W-1:0] lmag, rmag, lmax, rmax;
  logic [CFG_W:0]    cnt_inc;
  logic              accept, block_end;

  // magnitude; the most negative code maps onto 2^(SAMPLE_BITS-1)
  assign lmag = left_sample[SAMPLE_BITS-1]  ? PEAK_W'(-left_sample)  : PEAK_W'(left_sample);
  assign rmag = right_sample[SAMPLE_BITS-1] ? PEAK_W'(-right_sample) : PEAK_W'(right_sample);
  assign lmax = (lmag > lhold_r) ? lmag : lhold_r;
  assign rmax = (rmag > rhold_r) ? rmag : rhold_r;

  assign in_ready  = !fifo_full;
  assign accept    = in_valid && in_ready;
  assign cnt_inc   = {1'b0, cnt_r} + 1'b1;
  assign block_end = !(cnt_inc < {1'b0, frames_per_block});

  always_comb begin
    cnt_nxt   = cnt_r;
    lhold_nxt = lhold_r;
    rhold_nxt = rhold_r;
    push.valid = 1'b0;
    push.pair.left_peak  = lmax;
    push.pair.right_peak = rmax;
    if (accept) begin
      if (block_end) begin
        push.valid = 1'b1;
        cnt_nxt    = '0;
        lhold_nxt  = '0;
        rhold_nxt  = '0;
      end else begin
        cnt_nxt   = cnt_inc[CFG_W-1:0];
        lhold_nxt = lmax;
        rhold_nxt = rmax;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      lhold_r <= '0;
      rhold_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      lhold_r <= lhold_nxt;
      rhold_r <= rhold_nxt;
    end
  end

endmodule

[src/spd_fifo.sv]
// two-entry queue of peak pairs between the front and back ends
// depends on spd_pkg
module spd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spd_pkg::front_push_t push,
  input  logic                 pop,
  output logic                 full,
  output spd_pkg::fifo_rd_t    rd
);
  import spd_pkg::*;

  peak_pair_t            mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  do_push, do_pop;

  assign full         = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign rd.not_empty = (count_r != '0);
  assign rd.pair      = mem_r[rd_ptr_r];
  assign do_push      = push.valid && !full;
  assign do_pop       = pop && rd.not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.pair;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("fifo count beyond depth");

endmodule

[src/spd_log_unit.sv]
// iterative 20*log10 in Q8 dB: log2 by repeated squaring, then scaling
// depends on spd_pkg; one squaring per cycle
module spd_log_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [spd_pkg::LOG_IN_W-1:0] x,
  output logic                        done,
  output logic [spd_pkg::DB_W-1:0]    db
);
  import spd_pkg::*;

  log_state_t            state_r, state_nxt;
  logic [MANT_W-1:0]     m_r, m_nxt;
  logic [LOG_E_W-1:0]    e_r, e_nxt;
  logic [LOG_FRAC_W-1:0] frac_r, frac_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic [DB_W-1:0]       db_r, db_nxt;
  logic                  done_r, done_nxt;
  logic [LOG_IN_W-1:0]   x1, norm;
  logic [LOG_E_W-1:0]    top;
  logic [2*MANT_W-1:0]   sq;
  logic [MANT_W:0]       sq_q30;
  logic [38:0]           prod;

  assign x1 = (x == '0) ? LOG_IN_W'(1) : x;

  always_comb begin
    top = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (x1[i]) top = LOG_E_W'(i);
    end
  end

  assign norm   = x1 << (LOG_E_W'(LOG_IN_W - 1) - top);
  assign sq     = {{MANT_W{1'b0}}, m_r} * {{MANT_W{1'b0}}, m_r};
  assign sq_q30 = sq[2*MANT_W-1:30];
  assign prod   = 39'({e_r, frac_r}) * 39'(DB_PER_OCTAVE_Q16);

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    e_nxt     = e_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    db_nxt    = db_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      LOG_IDLE: begin
        if (start) begin
          m_nxt     = {norm, 15'b0};
          e_nxt     = top;
          frac_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = LOG_ITER;
        end
      end
      LOG_ITER: begin
        if (sq_q30[MANT_W]) begin
          m_nxt = sq_q30[MANT_W:1];
          frac_nxt[~cnt_r] = 1'b1;
        end else begin
          m_nxt = sq_q30[MANT_W-1:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'd15) state_nxt = LOG_SCALE;
      end
      LOG_SCALE: begin
        db_nxt    = prod[38:24];
        done_nxt  = 1'b1;
        state_nxt = LOG_IDLE;
      end
      default: state_nxt = LOG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    e_r    <= e_nxt;
    frac_r <= frac_nxt;
    db_r   <= db_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LOG_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  assign done = done_r;
  assign db   = db_r;

endmodule

[src/spd_back.sv]
// back end: pops peak pairs, runs four logs, forms bars and red counts
// depends on spd_pkg and spd_log_unit; owns the output register
module spd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spd_pkg::fifo_rd_t         rd,
  output logic                      pop,
  input  logic [spd_pkg::CFG_W-1:0] ref_amplitude,
  input  logic [spd_pkg::CFG_W-1:0] threshold_amplitude,
  output logic                      out_valid,
  input  logic                      out_ready,
  output spd_pkg::result_t          result
);
  import spd_pkg::*;

  localparam logic [1:0] SEL_LEFT  = 2'd0;
  localparam logic [1:0] SEL_RIGHT = 2'd1;
  localparam logic [1:0] SEL_REF   = 2'd2;
  localparam logic [1:0] SEL_THR   = 2'd3;

  back_state_t             state_r, state_nxt;
  logic [1:0]              sel_r, sel_nxt;
  peak_pair_t              pair_r;
  logic [DB_W-1:0]         db_r [4];
  logic signed [LVL_W-1:0] idx_l_r, idx_r_r, idx_t_r;
  logic                    out_valid_r;
  result_t                 result_r;
  logic                    log_start, log_done, load_out;
  logic [LOG_IN_W-1:0]     log_x;
  logic [DB_W-1:0]         log_db;
  logic [BAR_W-1:0]        bar_l, bar_r;

  always_comb begin
    case (sel_r)
      SEL_LEFT:  log_x = pair_r.left_peak;
      SEL_RIGHT: log_x = pair_r.right_peak;
      SEL_REF:   log_x = ref_amplitude;
      default:   log_x = threshold_amplitude;
    endcase
  end

  spd_log_unit u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .x     (log_x),
    .done  (log_done),
    .db    (log_db)
  );

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    pop       = 1'b0;
    log_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (rd.not_empty) begin
          pop       = 1'b1;
          sel_nxt   = SEL_LEFT;
          state_nxt = BK_START;
        end
      end
      BK_START: begin
        log_start = 1'b1;
        state_nxt = BK_WAIT;
      end
      BK_WAIT: begin
        if (log_done) begin
          if (sel_r == SEL_THR) begin
            state_nxt = BK_LEVEL;
          end else begin
            sel_nxt   = sel_r + 1'b1;
            state_nxt = BK_START;
          end
        end
      end
      BK_LEVEL: state_nxt = BK_OUT;
      BK_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign bar_l = bar_of(idx_l_r);
  assign bar_r = bar_of(idx_r_r);

  always_ff @(posedge clk) begin
    if (pop) pair_r <= rd.pair;
    if (state_r == BK_WAIT && log_done) db_r[sel_r] <= log_db;
    if (state_r == BK_LEVEL) begin
      idx_l_r <= level_of(db_r[SEL_LEFT],  db_r[SEL_REF]);
      idx_r_r <= level_of(db_r[SEL_RIGHT], db_r[SEL_REF]);
      idx_t_r <= level_of(db_r[SEL_THR],   db_r[SEL_REF]);
    end
    if (load_out) begin
      result_r.left_peak       <= pair_r.left_peak;
      result_r.right_peak      <= pair_r.right_peak;
      result_r.left_bar        <= bar_l;
      result_r.right_bar       <= bar_r;
      result_r.left_red_count  <= red_of(bar_l, idx_t_r);
      result_r.right_red_count <= red_of(bar_r, idx_t_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      sel_r       <= SEL_LEFT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    log_done |-> state_r == BK_WAIT)
    else $error("log result arrived outside the wait state");

  assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("loaded result not presented");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> result_r.left_bar <= BAR_W'(BAR_SEGMENTS)
                 && result_r.right_bar <= BAR_W'(BAR_SEGMENTS)
                 && result_r.left_red_count <= result_r.left_bar
                 && result_r.right_red_count <= result_r.right_bar)
    else $error("bar or red count out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == BK_IDLE && rd.not_empty)
    else $error("queue popped while busy or empty");

endmodule

[src/stereo_peak_db_bargraph_unit.sv]
// top level of the stereo peak meter with decibel bar graph
// depends on spd_pkg, spd_front, spd_fifo, spd_log_unit and spd_back
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata: left_sample, right_sample
//  out_    | out | out_tvalid/out_tready| out_tdata: peaks, bars, red counts
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_addr register index, cfg_data value
//
// one frame is taken per cycle while the queue has room; peak tracking is a compare per channel
// each block result passes through the back end: four 20*log10 runs on one shared log
// unit (setup, repeated squaring and scaling each), then level and output
// a two-entry queue of peak pairs parts the front from the back; the front stalls only
// when that queue is full, so blocks that close faster than the back end finishes them throttle the input
// the output register lets the back end start the next block while a result waits
// reset (synchronous, rst_n low) clears counters, peaks, queue and state machines and
// loads the register reset values; cfg_ready is always high
module stereo_peak_db_bargraph_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] left_sample, [31:16] right_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] left_peak, [31:16] right_peak, [38:32] left_bar, [45:39] right_bar,
  // [52:46] left_red_count, [59:53] right_red_count, [63:60] zero
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [spd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spd_pkg::CFG_W-1:0]      cfg_data
);
  import spd_pkg::*;

  logic [CFG_W-1:0] ref_r, thr_r, fpb_r;
  front_push_t      push;
  fifo_rd_t         rd;
  logic             fifo_full, pop;
  result_t          result;

  // config registers; writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
      thr_r <= THR_RESET;
      fpb_r <= FPB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_REF_AMPLITUDE:       ref_r <= cfg_data;
        REG_THRESHOLD_AMPLITUDE: thr_r <= cfg_data;
        REG_FRAMES_PER_BLOCK:    fpb_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: peak hold and block counting
  spd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .left_sample      (in_tdata[15:0]),
    .right_sample     (in_tdata[31:16]),
    .frames_per_block (fpb_r),
    .fifo_full        (fifo_full),
    .push             (push)
  );

  // queue of finished peak pairs
  spd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (fifo_full),
    .rd    (rd)
  );

  // back: logs, levels, bars and the output register
  spd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rd                  (rd),
    .pop                 (pop),
    .ref_amplitude       (ref_r),
    .threshold_amplitude (thr_r),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready),
    .result              (result)
  );

  assign out_tdata = {4'b0, result};

endmodule

[tb/sv/stereo_peak_db_bargraph_unit_tb.sv]
// self-checking testbench for stereo_peak_db_bargraph_unit: stereo frames in,
// per-block peaks, decibel bar lengths and red counts out, checked against a local predictor
// depends on spd_pkg and the unit under test only
`timescale 1ns / 1ps

module stereo_peak_db_bargraph_unit_tb;
  import spd_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 200;     // settle time for the back end after the last owed result
  localparam int HOLD_CYCLES  = 600;     // long receiver hold-off
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;   // [15:0] left_sample, [31:16] right_sample
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [15:0] left_peak, [31:16] right_peak, [38:32] left_bar, [45:39] right_bar,
  // [52:46] left_red_count, [59:53] right_red_count, [63:60] zero
  logic [63:0]           out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  stereo_peak_db_bargraph_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // predictor copy of the registers and the block state
  logic [15:0] ref_reg = REF_RESET;
  logic [15:0] thr_reg = THR_RESET;
  logic [15:0] fpb_reg = FPB_RESET;
  logic [15:0] frames_in_block = '0;
  logic [15:0] left_hold = '0;
  logic [15:0] right_hold = '0;

  result_t     pending_meters[$];   // block results still owed by the unit
  result_t     meter_got;
  result_t     meter_want;

  int          fail_count = 0;
  int          report_count = 0;
  bit          gaps_on = 1'b0;      // sender idles at random
  bit          stalls_on = 1'b0;    // receiver stalls at random
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;

  // |sample| of a 16-bit two's complement value; the most negative one gives 32768
  function automatic logic [15:0] abs_sample(input logic [15:0] s);
    return s[15] ? 16'(~s + 16'd1) : s;
  endfunction

  // log2 in Q16 by repeated squaring of the Q30 mantissa, truncating
  function automatic logic [31:0] octave_fix(input logic [31:0] x);
    logic [31:0] e;
    logic [31:0] frac;
    logic [63:0] m;
    if (x == 0) x = 1;
    e = 0;
    while (e < 30 && (x >> (e + 1)) != 0) e++;
    m = 64'(x) << (30 - e);
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[15-i] = 1'b1;
      end
    end
    return (e << 16) | frac;
  endfunction

  // 20*log10(x) in Q8 dB
  function automatic int decibel_q8(input logic [31:0] x);
    logic [63:0] prod;
    prod = 64'(octave_fix(x)) * 64'(DB_PER_OCTAVE_Q16);
    return int'(prod >> 24);
  endfunction

  // segments for amplitude a against the current reference, truncated toward zero
  function automatic int segment_index(input logic [15:0] a);
    int v;
    v = BAR_SEGMENTS * 256 + decibel_q8((a == 0) ? 32'd1 : 32'(a))
        - decibel_q8((ref_reg == 0) ? 32'd1 : 32'(ref_reg));
    if (v >= 0) return v >>> 8;
    return -((-v) >>> 8);
  endfunction

  function automatic int clamp_bar(input int idx);
    if (idx < 0) return 0;
    if (idx > BAR_SEGMENTS) return BAR_SEGMENTS;
    return idx;
  endfunction

  function automatic int red_segments(input int bar, input int thr_idx);
    if (thr_idx < 0 || thr_idx >= bar) return 0;
    return bar - thr_idx;
  endfunction

  // fold one accepted frame into the block; queue a result when the block closes
  task automatic absorb_frame(input logic [15:0] left_s, input logic [15:0] right_s);
    logic [15:0] lm;
    logic [15:0] rm;
    int          lb;
    int          rb;
    int          ti;
    result_t     r;
    lm = abs_sample(left_s);
    rm = abs_sample(right_s);
    if (lm > left_hold) left_hold = lm;
    if (rm > right_hold) right_hold = rm;
    // a zero block size acts as one; a lowered size closes the block on this frame
    if (32'(frames_in_block) + 1 < 32'(fpb_reg)) begin
      frames_in_block = frames_in_block + 16'd1;
    end else begin
      lb = clamp_bar(segment_index(left_hold));
      rb = clamp_bar(segment_index(right_hold));
      ti = segment_index((thr_reg == 0) ? 16'd1 : thr_reg);
      r.left_peak       = left_hold;
      r.right_peak      = right_hold;
      r.left_bar        = BAR_W'(lb);
      r.right_bar       = BAR_W'(rb);
      r.left_red_count  = BAR_W'(red_segments(lb, ti));
      r.right_red_count = BAR_W'(red_segments(rb, ti));
      pending_meters.push_back(r);
      frames_in_block = '0;
      left_hold = '0;
      right_hold = '0;
    end
  endtask

  // one frame transfer; in_tvalid stays high afterward until end_burst or a gap
  task automatic send_frame(input logic [15:0] left_s, input logic [15:0] right_s);
    while (gaps_on && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {right_s, left_s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_frame(left_s, right_s);
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  // wait for every owed result, then let the back end settle
  task automatic wait_drained();
    while (pending_meters.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (addr)
      REG_REF_AMPLITUDE:       ref_reg = value;
      REG_THRESHOLD_AMPLITUDE: thr_reg = value;
      REG_FRAMES_PER_BLOCK:    fpb_reg = value;
      default: ;
    endcase
  endtask

  // only called with the unit idle
  task automatic program_registers(input logic [15:0] ref_v, input logic [15:0] thr_v,
                                   input logic [15:0] fpb_v);
    write_register(REG_REF_AMPLITUDE, ref_v);
    write_register(REG_THRESHOLD_AMPLITUDE, thr_v);
    write_register(REG_FRAMES_PER_BLOCK, fpb_v);
    cfg_valid <= 1'b0;
  endtask

  // random sample: full range, a random small magnitude, or an extreme value
  function automatic logic [15:0] rand_sample();
    logic [15:0] mag;
    case ($urandom_range(0, 3))
      0: begin
        mag = 16'($urandom_range(0, (1 << $urandom_range(0, 15)) - 1));
        return $urandom_range(0, 1) ? 16'(-mag) : mag;
      end
      1: begin
        case ($urandom_range(0, 4))
          0:       return 16'h0000;
          1:       return 16'h0001;
          2:       return 16'hFFFF;
          3:       return 16'h7FFF;
          default: return 16'h8000;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_amplitude();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'd32768;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [15:0] rand_block_size();
    case ($urandom_range(0, 15))
      0:       return 16'd0;
      1:       return 16'($urandom_range(50, 300));
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  // reset values: frames gathered at the reset block size, then the size drops below the count
  task automatic test_reset_defaults();
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h0001, 16'hFFFF);
    send_frame(16'h0000, 16'h4000);
    end_burst();
    wait_drained();
    program_registers(ref_reg, thr_reg, 16'd2);
    send_frame(16'h1234, 16'hEDCB);
    end_burst();
    wait_drained();
  endtask

  // zero peak, smallest magnitudes and the most negative sample
  task automatic test_sample_extremes();
    program_registers(16'd32768, 16'd8231, 16'd1);
    send_frame(16'h0000, 16'h0000);
    send_frame(16'h0001, 16'hFFFF);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'hFFFF, 16'h0100);
    end_burst();
    wait_drained();
  endtask

  // zero reference and threshold are taken as one; index equal to bar gives no red
  task automatic test_zero_registers();
    program_registers(16'd0, 16'd0, 16'd1);
    send_frame(16'h0001, 16'h0000);
    send_frame(16'h8000, 16'h0002);
    send_frame(16'h0010, 16'h0100);
    end_burst();
    wait_drained();
  endtask

  // top reference, threshold above every bar and a negative threshold index
  task automatic test_top_registers();
    program_registers(16'hFFFF, 16'hFFFF, 16'd1);
    send_frame(16'h7FFF, 16'h8000);
    end_burst();
    wait_drained();
    program_registers(16'hFFFF, 16'd1, 16'd1);
    send_frame(16'h8000, 16'h0001);
    send_frame(16'h0400, 16'h0020);
    end_burst();
    wait_drained();
  endtask

  // zero block size closes a block on every frame
  task automatic test_zero_block_size();
    program_registers(16'd32768, 16'd16384, 16'd0);
    send_frame(16'h0123, 16'hFEDC);
    send_frame(16'h8000, 16'h7FFF);
    end_burst();
    wait_drained();
  endtask

  // largest block size, then lowered mid-block to the count already reached
  task automatic test_block_shrink();
    program_registers(16'd20000, 16'd3000, 16'hFFFF);
    send_frame(16'h0400, 16'hF000);
    send_frame(16'hC000, 16'h0005);
    send_frame(16'h0002, 16'h2000);
    end_burst();
    wait_drained();
    program_registers(16'd20000, 16'd3000, 16'd3);
    send_frame(16'h0001, 16'h0001);
    end_burst();
    wait_drained();
  endtask

  // receiver holds off while one-frame blocks keep coming, so the input stalls
  task automatic test_backpressure();
    bit saved_gaps;
    saved_gaps = gaps_on;
    program_registers(16'd32768, 16'd8231, 16'd1);
    hold_token <= hold_token + 1;
    gaps_on = 1'b0;
    for (int i = 0; i < 24; i++) send_frame(rand_sample(), rand_sample());
    end_burst();
    gaps_on = saved_gaps;
    wait_drained();
  endtask

  // phases of random settings, each followed by a full drain
  task automatic test_random_blocks(input int n_items);
    int          sent;
    int          phase_len;
    logic [15:0] ref_v;
    logic [15:0] thr_v;
    sent = 0;
    while (sent < n_items) begin
      ref_v = rand_amplitude();
      thr_v = $urandom_range(0, 1) ? rand_amplitude() : 16'(ref_v >> $urandom_range(0, 6));
      program_registers(ref_v, thr_v, rand_block_size());
      phase_len = $urandom_range(40, 120);
      for (int i = 0; i < phase_len && sent < n_items; i++) begin
        send_frame(rand_sample(), rand_sample());
        sent++;
      end
      end_burst();
      wait_drained();
    end
  endtask

  // receiver: random stalls, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stalls_on) begin
      out_tready <= ($urandom_range(0, 99) >= 25);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      fail_count++;
      if (report_count < 10) begin
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
      report_count++;
    end
  endtask

  // each result transfer is compared with the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_meters.size() == 0) begin
        fail_count++;
        if (report_count < 10) begin
          $display("unexpected result transfer: %h", out_tdata);
        end
        report_count++;
      end else begin
        meter_want = pending_meters.pop_front();
        meter_got  = result_t'(out_tdata[59:0]);
        check_field("left_peak", meter_got.left_peak, meter_want.left_peak);
        check_field("right_peak", meter_got.right_peak, meter_want.right_peak);
        check_field("left_bar", meter_got.left_bar, meter_want.left_bar);
        check_field("right_bar", meter_got.right_bar, meter_want.right_bar);
        check_field("left_red_count", meter_got.left_red_count, meter_want.left_red_count);
        check_field("right_red_count", meter_got.right_red_count,
                    meter_want.right_red_count);
        check_field("pad bits", out_tdata[63:60], 0);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_reset_defaults();
    test_sample_extremes();
    test_zero_registers();
    test_top_registers();
    test_zero_block_size();
    test_block_shrink();
    test_backpressure();

    test_random_blocks(RANDOM_ITEMS / 3);
    // long stretch with both sides always ready
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_blocks(RANDOM_ITEMS / 3);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_random_blocks(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    wait_drained();
    if (fail_count == 0 && pending_meters.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
